### hdl/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types and constants for the Euler-angle to rotation-matrix block.
// ----------------------------------------------------------------------------
package e2r_pkg;

  // Number of CORDIC micro-rotations, one pipeline stage each.
  localparam int CORDIC_STEPS = 28;

  // Internal widths: turn accumulator, CORDIC z, CORDIC x/y, final sine/cosine.
  localparam int TURN_W = 32;
  localparam int Z_W    = 33;
  localparam int XY_W   = 34;
  localparam int TRIG_W = 32;

  // CORDIC start value (gain compensation) and 1.0, both in Q30.
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XY_W-1:0] Q30_ONE     = 34'sd1073741824;

  // Quadrant codes of the turn.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Cosine and sine of one angle, Q30.
  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  // Arctangent of 2^-i as a fraction of a full turn scaled by 2^32.
  function automatic logic signed [Z_W-1:0] atan_turn(input int step);
    logic [31:0] v;
    unique case (step)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      default: v = 32'h00000000;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

### hdl/e2r_if.sv
// ----------------------------------------------------------------------------
// e2r_if
// Valid/ready channels: angle beats in, matrix beats out.
// ----------------------------------------------------------------------------
interface e2r_in_if #(parameter int ANGLE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_x;
  logic signed [ANGLE_BITS-1:0] angle_y;
  logic signed [ANGLE_BITS-1:0] angle_z;

  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2r_out_if #(parameter int COEF_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic signed [COEF_BITS-1:0] m00;
  logic signed [COEF_BITS-1:0] m01;
  logic signed [COEF_BITS-1:0] m02;
  logic signed [COEF_BITS-1:0] m10;
  logic signed [COEF_BITS-1:0] m11;
  logic signed [COEF_BITS-1:0] m12;
  logic signed [COEF_BITS-1:0] m20;
  logic signed [COEF_BITS-1:0] m21;
  logic signed [COEF_BITS-1:0] m22;
  logic                        has_rotation;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  has_rotation, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  has_rotation, output ready);
endinterface

### hdl/e2r_cordic_step.sv
// ----------------------------------------------------------------------------
// e2r_cordic_step
// One registered rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module e2r_cordic_step #(
  parameter int STEP = 0
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [e2r_pkg::XY_W-1:0]    x_i,
  input  logic signed [e2r_pkg::XY_W-1:0]    y_i,
  input  logic signed [e2r_pkg::Z_W-1:0]     z_i,
  input  logic [1:0]                         quad_i,
  input  logic                               zero_i,
  output logic signed [e2r_pkg::XY_W-1:0]    x_o,
  output logic signed [e2r_pkg::XY_W-1:0]    y_o,
  output logic signed [e2r_pkg::Z_W-1:0]     z_o,
  output logic [1:0]                         quad_o,
  output logic                               zero_o
);
  import e2r_pkg::*;

  logic signed [XY_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [Z_W-1:0]  z_d, z_q;
  logic [1:0]             quad_q;
  logic                   zero_q;

  // Rotate toward zero residue; both shifts use the old x and y.
  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[Z_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_turn(STEP);
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_turn(STEP);
    end
  end

  // Stage register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      quad_q <= quad_i;
      zero_q <= zero_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign quad_o = quad_q;
  assign zero_o = zero_q;

endmodule

### hdl/e2r_sincos.sv
// ----------------------------------------------------------------------------
// e2r_sincos
// Pipelined sine and cosine of one binary angle: quadrant split, a chain of
// CORDIC stages and a quadrant restore.
// ----------------------------------------------------------------------------
module e2r_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output e2r_pkg::trig_t               trig_o
);
  import e2r_pkg::*;

  logic [TURN_W-1:0]      turn, turn_rnd, resid;
  logic [1:0]             quad_d;
  logic signed [XY_W-1:0] x_s [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_s [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_s [0:CORDIC_STEPS];
  logic [1:0]             quad_s [0:CORDIC_STEPS];
  logic                   zero_s [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] x_f, y_f, nx_f, ny_f;
  trig_t                  trig_d, trig_q;

  // Scale the angle to a 32-bit turn and split off the nearest quadrant.
  always_comb begin
    turn     = {angle_i, {(TURN_W-ANGLE_BITS){1'b0}}};
    turn_rnd = turn + 32'h2000_0000;
    quad_d   = turn_rnd[TURN_W-1:TURN_W-2];
    resid    = turn - {quad_d, {(TURN_W-2){1'b0}}};
  end

  // Entry register of the rotation chain.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_s[0]    <= CORDIC_GAIN;
      y_s[0]    <= '0;
      z_s[0]    <= $signed({resid[TURN_W-1], resid});
      quad_s[0] <= quad_d;
      zero_s[0] <= (resid == '0);
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    e2r_cordic_step #(.STEP(i)) u_step (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .z_i    (z_s[i]),
      .quad_i (quad_s[i]),
      .zero_i (zero_s[i]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .z_o    (z_s[i+1]),
      .quad_o (quad_s[i+1]),
      .zero_o (zero_s[i+1])
    );
  end

  // An exact quadrant angle takes exact 1.0 and 0; then restore the quadrant.
  always_comb begin
    x_f  = zero_s[CORDIC_STEPS] ? Q30_ONE : x_s[CORDIC_STEPS];
    y_f  = zero_s[CORDIC_STEPS] ? '0 : y_s[CORDIC_STEPS];
    nx_f = -x_f;
    ny_f = -y_f;
    unique case (quad_s[CORDIC_STEPS])
      QUAD_0: begin
        trig_d.c = x_f[TRIG_W-1:0];
        trig_d.s = y_f[TRIG_W-1:0];
      end
      QUAD_1: begin
        trig_d.c = ny_f[TRIG_W-1:0];
        trig_d.s = x_f[TRIG_W-1:0];
      end
      QUAD_2: begin
        trig_d.c = nx_f[TRIG_W-1:0];
        trig_d.s = ny_f[TRIG_W-1:0];
      end
      QUAD_3: begin
        trig_d.c = y_f[TRIG_W-1:0];
        trig_d.s = nx_f[TRIG_W-1:0];
      end
      default: begin
        trig_d.c = x_f[TRIG_W-1:0];
        trig_d.s = y_f[TRIG_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

endmodule

### hdl/e2r_matrix.sv
// ----------------------------------------------------------------------------
// e2r_matrix
// Three-stage product and sum network that builds the nine matrix entries
// from the sines and cosines, with rounding and saturation to Q1.(N-1).
// ----------------------------------------------------------------------------
module e2r_matrix #(
  parameter int COEF_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  e2r_pkg::trig_t              tx_i,
  input  e2r_pkg::trig_t              ty_i,
  input  e2r_pkg::trig_t              tz_i,
  output logic signed [COEF_BITS-1:0] m00_o,
  output logic signed [COEF_BITS-1:0] m01_o,
  output logic signed [COEF_BITS-1:0] m02_o,
  output logic signed [COEF_BITS-1:0] m10_o,
  output logic signed [COEF_BITS-1:0] m11_o,
  output logic signed [COEF_BITS-1:0] m12_o,
  output logic signed [COEF_BITS-1:0] m20_o,
  output logic signed [COEF_BITS-1:0] m21_o,
  output logic signed [COEF_BITS-1:0] m22_o
);
  import e2r_pkg::*;

  localparam int SUM_W = TRIG_W + 1;
  localparam int SHIFT = 31 - COEF_BITS;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (SHIFT - 1);
  localparam logic signed [SUM_W-1:0] LIM = (SUM_W'(1) <<< (COEF_BITS - 1)) - 1;

  // Q30 by Q30 product, rounded to nearest with ties upward.
  function automatic logic signed [TRIG_W-1:0] qmul(
    input logic signed [TRIG_W-1:0] a,
    input logic signed [TRIG_W-1:0] b
  );
    logic signed [2*TRIG_W-1:0] p;
    p = (a * b) + 64'sd536870912;
    return p[TRIG_W+29:30];
  endfunction

  // Round from Q30 to the output format and clamp symmetrically.
  function automatic logic signed [COEF_BITS-1:0] to_coef(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    r = (v + RND) >>> SHIFT;
    if (r > LIM) begin
      r = LIM;
    end else if (r < -LIM) begin
      r = -LIM;
    end
    return r[COEF_BITS-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [TRIG_W-1:0] a);
    return $signed({a[TRIG_W-1], a});
  endfunction

  logic signed [TRIG_W-1:0] r1_q, r2_q, r3_q, r4_q, cxsy_q, cxsz_q, cxcz_q, cxcy_q;
  logic signed [TRIG_W-1:0] sx_q;
  logic signed [TRIG_W-1:0] r1_c_q, r2_c_q, r3_c_q, r4_c_q;
  logic signed [TRIG_W-1:0] cxsy_c_q, cxsz_c_q, cxcz_c_q, cxcy_c_q, sx_c_q;
  logic signed [TRIG_W-1:0] p00_q, p01_q, p20_q, p21_q;
  logic signed [COEF_BITS-1:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q;
  logic signed [COEF_BITS-1:0] m20_q, m21_q, m22_q;

  // First products: the y-z terms and the cos(x) terms.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q   <= qmul(ty_i.c, tz_i.c);
      r2_q   <= qmul(ty_i.c, tz_i.s);
      r3_q   <= qmul(ty_i.s, tz_i.c);
      r4_q   <= qmul(ty_i.s, tz_i.s);
      cxsy_q <= qmul(tx_i.c, ty_i.s);
      cxsz_q <= qmul(tx_i.c, tz_i.s);
      cxcz_q <= qmul(tx_i.c, tz_i.c);
      cxcy_q <= qmul(tx_i.c, ty_i.c);
      sx_q   <= tx_i.s;
    end
  end

  // Second products: the y-z terms scaled by sin(x).
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q    <= qmul(r4_q, sx_q);
      p01_q    <= qmul(r3_q, sx_q);
      p20_q    <= qmul(r2_q, sx_q);
      p21_q    <= qmul(r1_q, sx_q);
      r1_c_q   <= r1_q;
      r2_c_q   <= r2_q;
      r3_c_q   <= r3_q;
      r4_c_q   <= r4_q;
      cxsy_c_q <= cxsy_q;
      cxsz_c_q <= cxsz_q;
      cxcz_c_q <= cxcz_q;
      cxcy_c_q <= cxcy_q;
      sx_c_q   <= sx_q;
    end
  end

  // Final sums, rounding and saturation into the output register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m00_q <= to_coef(ext(r1_c_q) - ext(p00_q));
      m01_q <= to_coef(ext(r2_c_q) + ext(p01_q));
      m02_q <= to_coef(-ext(cxsy_c_q));
      m10_q <= to_coef(-ext(cxsz_c_q));
      m11_q <= to_coef(ext(cxcz_c_q));
      m12_q <= to_coef(ext(sx_c_q));
      m20_q <= to_coef(ext(r3_c_q) + ext(p20_q));
      m21_q <= to_coef(ext(r4_c_q) - ext(p21_q));
      m22_q <= to_coef(ext(cxcy_c_q));
    end
  end

  assign m00_o = m00_q;
  assign m01_o = m01_q;
  assign m02_o = m02_q;
  assign m10_o = m10_q;
  assign m11_o = m11_q;
  assign m12_o = m12_q;
  assign m20_o = m20_q;
  assign m21_o = m21_q;
  assign m22_o = m22_q;

endmodule

### hdl/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Euler angles (x, y, z) in binary angle units to a 3x3 rotation matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one beat of three signed binary angles (a full turn is
//   2^ANGLE_BITS). out_o returns one beat per input beat, in order: the nine
//   entries m00..m22 in signed Q1.(COEF_BITS-1), saturated to +-max code, and
//   has_rotation, which is low only when all three angles are zero.
//   The pipeline has one quadrant split stage, 28 CORDIC stages, one
//   quadrant restore stage and three product/sum stages, the last of which
//   is the output register.
//   Throughput is one beat per cycle while out_o is not stalled; the three
//   sine/cosine chains run in parallel, every stage taking a beat each cycle.
//   A stall on out_o freezes the whole pipeline as long as the output beat
//   is held; in_i.ready is then low, and every beat in flight is kept.
//   Asynchronous reset empties the pipeline; no output beat is valid after
//   reset until new beats have passed through.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  e2r_in_if.sink   in_i,
  e2r_out_if.source out_o
);
  import e2r_pkg::*;

  localparam int LATENCY = CORDIC_STEPS + 5;

  logic               en;
  logic [LATENCY-1:0] vld_q, vld_d;
  logic [LATENCY-1:0] rot_q, rot_d;
  logic               rot_in;
  trig_t              tx, ty, tz;

  // The pipeline moves whenever the output register is free or being read.
  assign en         = !vld_q[LATENCY-1] || out_o.ready;
  assign in_i.ready = en;
  assign rot_in     = (in_i.angle_x != '0) || (in_i.angle_y != '0) ||
                      (in_i.angle_z != '0);

  // Valid bits and the rotation flag travel alongside the data.
  always_comb begin
    vld_d = {vld_q[LATENCY-2:0], in_i.valid};
    rot_d = {rot_q[LATENCY-2:0], rot_in};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_q <= rot_d;
    end
  end

  // Sine and cosine of each angle.
  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
    .clk_i (clk_i), .en_i (en), .angle_i (in_i.angle_x), .trig_o (tx)
  );
  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
    .clk_i (clk_i), .en_i (en), .angle_i (in_i.angle_y), .trig_o (ty)
  );
  e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
    .clk_i (clk_i), .en_i (en), .angle_i (in_i.angle_z), .trig_o (tz)
  );

  // Matrix products and output register.
  e2r_matrix #(.COEF_BITS(COEF_BITS)) u_matrix (
    .clk_i (clk_i),
    .en_i  (en),
    .tx_i  (tx),
    .ty_i  (ty),
    .tz_i  (tz),
    .m00_o (out_o.m00),
    .m01_o (out_o.m01),
    .m02_o (out_o.m02),
    .m10_o (out_o.m10),
    .m11_o (out_o.m11),
    .m12_o (out_o.m12),
    .m20_o (out_o.m20),
    .m21_o (out_o.m21),
    .m22_o (out_o.m22)
  );

  assign out_o.valid        = vld_q[LATENCY-1];
  assign out_o.has_rotation = rot_q[LATENCY-1];

endmodule
